>>> src/sst_pkg.sv
package sst_pkg;

  localparam int TAG_W   = 4;
  localparam int ID_W    = 27;
  localparam int SCORE_W = 8;

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_DELETE = 2'd1,
    OP_CHANGE = 2'd2,
    OP_LIST   = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    ST_DONE     = 3'd0,
    ST_FULL     = 3'd1,
    ST_NOTFOUND = 3'd2,
    ST_LISTED   = 3'd3,
    ST_EMPTY    = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_CHG_INS,
    S_LIST
  } back_state_t;

  typedef struct packed {
    logic [TAG_W-1:0]   tag;
    logic [ID_W-1:0]    id;
    logic [SCORE_W-1:0] score;
  } entry_t;

  // One decoded command as it travels from the front end to the table
  typedef struct packed {
    op_t                op;
    logic [TAG_W-1:0]   tag;
    logic [ID_W-1:0]    id;
    logic [SCORE_W-1:0] score;
  } cmd_t;

  // One result as it leaves the table engine
  typedef struct packed {
    status_t            status;
    logic [TAG_W-1:0]   tag;
    logic [ID_W-1:0]    id;
    logic [SCORE_W-1:0] score;
    logic               last;
  } rsp_t;

endpackage

>>> src/sst_in_if.sv
interface sst_in_if import sst_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [1:0]         operation;
  logic [TAG_W-1:0]   tag;
  logic [ID_W-1:0]    student_id;
  logic [SCORE_W-1:0] score;

  modport source (output valid, operation, tag, student_id, score, input ready);
  modport sink   (input valid, operation, tag, student_id, score, output ready);
endinterface

>>> src/sst_out_if.sv
interface sst_out_if import sst_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [2:0]         status;
  logic [TAG_W-1:0]   out_tag;
  logic [ID_W-1:0]    out_id;
  logic [SCORE_W-1:0] out_score;
  logic               last;

  modport source (output valid, status, out_tag, out_id, out_score, last, input ready);
  modport sink   (input valid, status, out_tag, out_id, out_score, last, output ready);
endinterface

>>> src/sorted_score_table_unit.sv
// Path: front hold register, two-entry command queue, table engine, output register.
// Throughput, set by the single table engine while the output is free: one insert or
// delete per cycle; a change deletes, then re-inserts from a second state; a list emits
// one entry per cycle, or an empty result when none match.
// Reset (rst, synchronous): table empties, queue and output valid flag are cleared.
module sorted_score_table_unit import sst_pkg::*; #(
  parameter int DEPTH = 16
) (
  input  logic     clk,
  input  logic     rst,
  sst_in_if.sink   req,
  sst_out_if.source rsp
);

  logic cmd_valid;
  cmd_t cmd;
  logic q_space;
  logic q_avail;
  cmd_t q_data;
  logic q_pop;
  logic out_valid;
  rsp_t out_rsp;

  sst_front u_front (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_ready (q_space)
  );

  sst_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (cmd_valid),
    .push_data (cmd),
    .space     (q_space),
    .avail     (q_avail),
    .pop_data  (q_data),
    .pop       (q_pop)
  );

  sst_back #(.DEPTH(DEPTH)) u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (q_avail),
    .cmd       (q_data),
    .cmd_pop   (q_pop),
    .out_valid (out_valid),
    .out_rsp   (out_rsp),
    .out_ready (rsp.ready)
  );

  assign rsp.valid     = out_valid;
  assign rsp.status    = out_rsp.status;
  assign rsp.out_tag   = out_rsp.tag;
  assign rsp.out_id    = out_rsp.id;
  assign rsp.out_score = out_rsp.score;
  assign rsp.last      = out_rsp.last;

  // Only list entries can be followed by more results of the same command
  a_single_last: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && (rsp.status != ST_LISTED) |-> rsp.last)
    else $error("non-list result without last");

  // Non-list results carry an empty payload
  a_zero_payload: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && (rsp.status != ST_LISTED) |->
      (rsp.out_tag == '0) && (rsp.out_id == '0) && (rsp.out_score == '0))
    else $error("non-list result with payload");

  // The engine never pops an empty queue
  a_pop_avail: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> q_avail)
    else $error("pop from empty command queue");

endmodule

>>> src/sst_front.sv
module sst_front import sst_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  sst_in_if.sink      req,
  output logic        cmd_valid,
  output cmd_t        cmd,
  input  logic        cmd_ready
);

  logic hold_valid;
  cmd_t hold;
  cmd_t decoded;

  // Decode the incoming transaction into a command
  always_comb begin
    decoded.op    = op_t'(req.operation);
    decoded.tag   = req.tag;
    decoded.id    = req.student_id;
    decoded.score = req.score;
  end

  assign req.ready = !hold_valid || cmd_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (req.ready) begin
      hold_valid <= req.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (req.valid && req.ready) begin
      hold <= decoded;
    end
  end

  assign cmd_valid = hold_valid;
  assign cmd       = hold;

endmodule

>>> src/sst_fifo.sv
module sst_fifo import sst_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  cmd_t push_data,
  output logic space,
  output logic avail,
  output cmd_t pop_data,
  input  logic pop
);

  // Two-entry command queue
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  cmd_t       mem [2];

  assign space    = (count != 2'd2);
  assign avail    = (count != 2'd0);
  assign pop_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push && space) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop && avail) begin
        rd_ptr <= !rd_ptr;
      end
      count <= count + 2'(push && space) - 2'(pop && avail);
    end
  end

  always_ff @(posedge clk) begin
    if (push && space) begin
      mem[wr_ptr] <= push_data;
    end
  end

endmodule

>>> src/sst_back.sv
module sst_back import sst_pkg::*; #(
  parameter int DEPTH = 16
) (
  input  logic clk,
  input  logic rst,
  input  logic cmd_valid,
  input  cmd_t cmd,
  output logic cmd_pop,
  output logic out_valid,
  output rsp_t out_rsp,
  input  logic out_ready
);

  localparam int IDX_W = $clog2(DEPTH);

  back_state_t state, state_next;

  // Table cells: valid entries always form a prefix of the slots
  logic [DEPTH-1:0] valid, valid_next;
  entry_t           ent [DEPTH];
  entry_t           ent_next [DEPTH];

  // Saved operands
  entry_t             chg;
  logic [SCORE_W-1:0] thr;
  logic [IDX_W-1:0]   idx;

  logic out_free;
  logic do_ins, do_del, emit;
  logic start_chg, start_list;
  rsp_t rsp_d;

  entry_t           ins_ent;
  logic [DEPTH-1:0] gt, hit, first_hit, del_mask, lst_match, lst_after;
  logic             found, full, list_nonempty;
  logic [ID_W-1:0]  hit_id;

  assign out_free = !out_valid || out_ready;
  assign full     = valid[DEPTH-1];

  // Operand for an insert: new item, or the entry being moved
  always_comb begin
    if (state == S_CHG_INS) begin
      ins_ent = chg;
    end else begin
      ins_ent.tag   = cmd.tag;
      ins_ent.id    = cmd.id;
      ins_ent.score = cmd.score;
    end
  end

  // Per-cell compares
  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      gt[i] = valid[i] && ((ent[i].score > ins_ent.score) ||
              ((ent[i].score == ins_ent.score) && (ent[i].id <= ins_ent.id)));
      hit[i]       = valid[i] && (ent[i].tag == cmd.tag);
      lst_match[i] = valid[i] && (ent[i].score > thr);
    end
  end

  // First tag match and the slots from it upward
  assign found     = |hit;
  assign first_hit = hit & (~hit + DEPTH'(1));
  assign del_mask  = found ? ~(first_hit - DEPTH'(1)) : '0;
  assign lst_after = lst_match >> 1;
  assign list_nonempty = valid[0] && (ent[0].score > cmd.score);

  always_comb begin
    hit_id = '0;
    for (int i = 0; i < DEPTH; i++) begin
      if (first_hit[i]) begin
        hit_id = hit_id | ent[i].id;
      end
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (cmd_valid && out_free) begin
          if (cmd.op == OP_CHANGE && found) begin
            state_next = S_CHG_INS;
          end else if (cmd.op == OP_LIST && list_nonempty) begin
            state_next = S_LIST;
          end
        end
      end
      S_CHG_INS: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      S_LIST: begin
        if (out_free && (idx == IDX_W'(DEPTH - 1) || !lst_after[idx])) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Control and result
  always_comb begin
    cmd_pop    = 1'b0;
    do_ins     = 1'b0;
    do_del     = 1'b0;
    emit       = 1'b0;
    start_chg  = 1'b0;
    start_list = 1'b0;
    rsp_d      = '0;
    rsp_d.last = 1'b1;
    case (state)
      S_IDLE: begin
        if (cmd_valid && out_free) begin
          cmd_pop = 1'b1;
          case (cmd.op)
            OP_INSERT: begin
              emit = 1'b1;
              if (full) begin
                rsp_d.status = ST_FULL;
              end else begin
                do_ins       = 1'b1;
                rsp_d.status = ST_DONE;
              end
            end
            OP_DELETE: begin
              emit = 1'b1;
              if (found) begin
                do_del       = 1'b1;
                rsp_d.status = ST_DONE;
              end else begin
                rsp_d.status = ST_NOTFOUND;
              end
            end
            OP_CHANGE: begin
              if (found) begin
                do_del    = 1'b1;
                start_chg = 1'b1;
              end else begin
                emit         = 1'b1;
                rsp_d.status = ST_NOTFOUND;
              end
            end
            OP_LIST: begin
              if (list_nonempty) begin
                start_list = 1'b1;
              end else begin
                emit         = 1'b1;
                rsp_d.status = ST_EMPTY;
              end
            end
            default: ;
          endcase
        end
      end
      S_CHG_INS: begin
        if (out_free) begin
          do_ins       = 1'b1;
          emit         = 1'b1;
          rsp_d.status = ST_DONE;
        end
      end
      S_LIST: begin
        if (out_free) begin
          emit         = 1'b1;
          rsp_d.status = ST_LISTED;
          rsp_d.tag    = ent[idx].tag;
          rsp_d.id     = ent[idx].id;
          rsp_d.score  = ent[idx].score;
          rsp_d.last   = (idx == IDX_W'(DEPTH - 1)) || !lst_after[idx];
        end
      end
      default: ;
    endcase
  end

  // Shift network: open a slot for insert, close the gap for delete
  always_comb begin
    valid_next = valid;
    for (int i = 0; i < DEPTH; i++) begin
      ent_next[i] = ent[i];
    end
    if (do_ins) begin
      valid_next = {valid[DEPTH-2:0], 1'b1};
      if (!gt[0]) begin
        ent_next[0] = ins_ent;
      end
      for (int i = 1; i < DEPTH; i++) begin
        if (!gt[i]) begin
          ent_next[i] = gt[i-1] ? ins_ent : ent[i-1];
        end
      end
    end else if (do_del) begin
      valid_next = valid >> 1;
      for (int i = 0; i < DEPTH - 1; i++) begin
        if (del_mask[i]) begin
          ent_next[i] = ent[i+1];
        end
      end
      if (del_mask[DEPTH-1]) begin
        ent_next[DEPTH-1] = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      valid     <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      valid <= valid_next;
      if (out_free) begin
        out_valid <= emit;
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < DEPTH; i++) begin
      ent[i] <= ent_next[i];
    end
    if (emit) begin
      out_rsp <= rsp_d;
    end
    if (start_chg) begin
      chg.tag   <= cmd.tag;
      chg.id    <= hit_id;
      chg.score <= cmd.score;
    end
    if (start_list) begin
      thr <= cmd.score;
      idx <= '0;
    end else if (state == S_LIST && out_free) begin
      idx <= idx + IDX_W'(1);
    end
  end

endmodule
